[rtl/three_frame_motion_mask_top_defines.svh]
// three_frame_motion_mask_top_defines.svh: assertion macros for the motion mask block
// depends on nothing; the including module must provide clk and rst_n
`ifndef THREE_FRAME_MOTION_MASK_TOP_DEFINES_SVH
`define THREE_FRAME_MOTION_MASK_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define TFMM_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfmm: same-cycle check failed");

// next-cycle implication, held off during reset
`define TFMM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfmm: next-cycle check failed");

`endif

[rtl/tfmm_pkg.sv]
// tfmm_pkg: sizes, register indexes, request and result types, clamp helper
// shared by every module of the three frame motion mask block; no dependencies
package tfmm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 3;

    localparam int CFG_W   = 11;
    localparam int PIX_W   = 8;
    localparam int THR_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_A_W = (CFG_W > WID_W) ? CFG_W : WID_W;
    localparam int CMP_W   = (CMP_A_W > ROW_W) ? CMP_A_W : ROW_W;
    localparam int WIN_W   = 3;

    localparam int OPQ_DEPTH = 2;
    localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = CFG_IDX_W'(2);

    // request kinds carried on cmd
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;
    localparam int RESET_THRESHOLD    = 30;

    // one classified request from the front to the back
    typedef struct packed {
        logic             pixel;      // real pixel: line buffers updated
        logic             rd_er1;     // drain row: column taken from the eroded-or line
        logic [COL_W-1:0] col;
        logic             col_zero;
        logic             col_one;
        logic             row_zero;
        logic             emit;       // a result comes out of this request
        logic             last;       // final mask pixel of the frame
        logic             t;          // thresholded bit
    } op_t;

    typedef struct packed {
        logic motion_bit;
        logic frame_last;
    } res_t;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        logic [CMP_W-1:0] x;
        x = CMP_W'(v);
        if (x < CMP_W'(MIN_DIM)) begin
            return CMP_W'(MIN_DIM);
        end
        else if (x > CMP_W'(hi)) begin
            return CMP_W'(hi);
        end
        return x;
    endfunction

endpackage

[rtl/tfmm_op_queue.sv]
// tfmm_op_queue: short queue of classified requests between front and back
// depends on tfmm_pkg
module tfmm_op_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tfmm_pkg::op_t  din,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output tfmm_pkg::op_t  dout
);
    import tfmm_pkg::*;

    op_t                  mem_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == OPQ_CNT_W'(OPQ_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + OPQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + OPQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OPQ_CNT_W'(push) - OPQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/tfmm_result_fifo.sv]
// tfmm_result_fifo: output queue of mask results, popped by the consumer
// depends on tfmm_pkg
module tfmm_result_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  tfmm_pkg::res_t                din,
    input  logic                          pop,
    output logic                          empty,
    output tfmm_pkg::res_t                dout,
    output logic [tfmm_pkg::RES_CNT_W-1:0] count
);
    import tfmm_pkg::*;

    res_t                 mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 pop_fire;

    assign empty    = (count_reg == '0);
    assign pop_fire = pop && !empty;
    assign dout     = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb
    begin
        count_next = count_reg + RES_CNT_W'(push) - RES_CNT_W'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_W'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/tfmm_front.sv]
// tfmm_front: accepts pixel triples, thresholds them and tracks the raster position
// depends on tfmm_pkg; feeds tfmm_op_queue
module tfmm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        cmd,
    input  logic [tfmm_pkg::PIX_W-1:0]  prev_pixel,
    input  logic [tfmm_pkg::PIX_W-1:0]  cur_pixel,
    input  logic [tfmm_pkg::PIX_W-1:0]  next_pixel,
    input  logic [tfmm_pkg::WID_W-1:0]  frame_w,
    input  logic [tfmm_pkg::ROW_W-1:0]  frame_h,
    input  logic [tfmm_pkg::THR_W-1:0]  threshold,
    input  logic                        queue_full,
    output logic                        op_push,
    output tfmm_pkg::op_t               op
);
    import tfmm_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WID_W-1:0] col_inc;
    logic [PIX_W-1:0] diff_a, diff_b;
    logic             draining, row_past, col_zero, drop, accept;

    assign accept   = push && !queue_full;
    assign draining = (row_reg >= frame_h);
    assign row_past = (row_reg > frame_h);
    assign col_zero = (col_reg == '0);
    // flush before the last pixel is dropped
    assign drop     = !draining && (cmd == CMD_FLUSH);
    assign op_push  = accept && !drop;
    assign col_inc  = WID_W'(col_reg) + WID_W'(1);

    always_comb
    begin
        diff_a = (prev_pixel > cur_pixel) ? prev_pixel - cur_pixel : cur_pixel - prev_pixel;
        diff_b = (cur_pixel > next_pixel) ? cur_pixel - next_pixel : next_pixel - cur_pixel;

        op.pixel    = !draining;
        op.rd_er1   = draining && (row_reg == frame_h);
        op.col      = col_reg;
        op.col_zero = col_zero;
        op.col_one  = (col_reg == COL_W'(1));
        op.row_zero = (row_reg == '0);
        op.emit     = col_zero ? (row_reg >= ROW_W'(2)) : (row_reg != '0);
        op.last     = col_zero && row_past;
        op.t        = ((diff_a & diff_b) > threshold);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (draining && row_past && col_zero)
        begin
            // tail drained, next frame starts
            col_next = '0;
            row_next = '0;
        end
        else if (!drop)
        begin
            if (col_inc >= frame_w)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/tfmm_back.sv]
// tfmm_back: line buffer read stage, erosion, dilation window and result build
// depends on tfmm_pkg; pushes into tfmm_result_fifo
module tfmm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           op_valid,
    input  tfmm_pkg::op_t                  op,
    input  logic [tfmm_pkg::RES_CNT_W-1:0] res_count,
    output logic                           op_pop,
    output logic                           res_push,
    output tfmm_pkg::res_t                 res
);
    import tfmm_pkg::*;

    localparam logic [WIN_W-1:0] MASK_TWO   = WIN_W'(3);
    localparam logic [WIN_W-1:0] MASK_THREE = WIN_W'(7);

    logic thresh_row_mem [MAX_WIDTH];
    logic ero_last_mem   [MAX_WIDTH];
    logic ero_or_mem     [MAX_WIDTH];

    op_t              b_op_reg;
    logic             up_reg, ero_last_reg, ero_or_reg;
    logic             b_valid_reg;
    logic             left_reg, upleft_reg;
    logic [WIN_W-1:0] win_reg, win_next, win_shift;
    logic             ero, ero_or_new, col_bit, motion;
    logic             a_fire;

    // room for every request already in flight, so the result stage never waits
    assign a_fire = op_valid &&
        ((RES_CNT_W + 1)'(res_count) + (RES_CNT_W + 1)'(b_valid_reg)
         < (RES_CNT_W + 1)'(RES_DEPTH));
    assign op_pop = a_fire;

    always_comb
    begin
        ero = b_op_reg.t
            & (b_op_reg.col_zero | left_reg)
            & (b_op_reg.row_zero | up_reg)
            & (b_op_reg.col_zero | b_op_reg.row_zero | upleft_reg);
        ero_or_new = (b_op_reg.row_zero ? 1'b0 : ero_last_reg) | ero;

        if (b_op_reg.pixel)
        begin
            col_bit = b_op_reg.row_zero ? ero : (ero_or_reg | ero);
        end
        else
        begin
            col_bit = b_op_reg.rd_er1 && ero_or_reg;
        end

        win_shift = {win_reg[WIN_W-2:0], col_bit}
            & (b_op_reg.col_one ? MASK_TWO : MASK_THREE);
        if (b_op_reg.col_zero)
        begin
            // closes the previous line: only its last two columns count
            motion   = win_reg[0] | win_reg[1];
            win_next = WIN_W'(col_bit);
        end
        else
        begin
            motion   = (win_shift != '0);
            win_next = win_shift;
        end

        res_push       = b_valid_reg && b_op_reg.emit;
        res.motion_bit = motion;
        res.frame_last = b_op_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            left_reg    <= 1'b0;
            upleft_reg  <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= a_fire;
            if (b_valid_reg)
            begin
                win_reg <= win_next;
                if (b_op_reg.pixel)
                begin
                    left_reg   <= b_op_reg.t;
                    upleft_reg <= up_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_op_reg     <= op;
            up_reg       <= thresh_row_mem[op.col];
            ero_last_reg <= ero_last_mem[op.col];
            ero_or_reg   <= ero_or_mem[op.col];
        end
        if (b_valid_reg && b_op_reg.pixel)
        begin
            thresh_row_mem[b_op_reg.col] <= b_op_reg.t;
            ero_last_mem[b_op_reg.col]   <= ero;
            ero_or_mem[b_op_reg.col]     <= ero_or_new;
        end
    end

endmodule

[rtl/three_frame_motion_mask_top.sv]
// a request that yields a result passes the request queue, the back stage and the
// result queue to the result ports; the mask lags the input by one line plus one pixel
// throughput: one request per cycle unless the back waits for result queue credit,
// set by the per-column read-modify-write of the line buffers (one read and one
// write port each, read data registered); reset: counters, window and queues cleared,
// registers back to 640x480 threshold 30; line buffers not cleared, invalid until written
`include "three_frame_motion_mask_top_defines.svh"

module three_frame_motion_mask_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            push,
    output logic                            full,
    input  logic                            cmd,
    input  logic [tfmm_pkg::PIX_W-1:0]      prev_pixel,
    input  logic [tfmm_pkg::PIX_W-1:0]      cur_pixel,
    input  logic [tfmm_pkg::PIX_W-1:0]      next_pixel,
    // configuration writes
    input  logic                            cfg_write,
    input  logic [tfmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfmm_pkg::CFG_W-1:0]      cfg_data,
    // result side
    output logic                            empty,
    input  logic                            pop,
    output logic                            motion_bit,
    output logic                            frame_last
);
    import tfmm_pkg::*;

    // sizes are stored already clamped, so the datapath never sees an
    // out-of-range width or height
    logic [WID_W-1:0]     width_reg;
    logic [ROW_W-1:0]     height_reg;
    logic [THR_W-1:0]     threshold_reg;

    logic                 op_push, op_pop, op_full, op_valid;
    op_t                  op_in, op_out;
    logic                 res_push;
    res_t                 res_in, res_out;
    logic [RES_CNT_W-1:0] res_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WID_W'(clamp_dim(CFG_W'(RESET_FRAME_WIDTH), MAX_WIDTH));
            height_reg    <= ROW_W'(clamp_dim(CFG_W'(RESET_FRAME_HEIGHT), MAX_HEIGHT));
            threshold_reg <= THR_W'(RESET_THRESHOLD);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:
                begin
                    width_reg <= WID_W'(clamp_dim(cfg_data, MAX_WIDTH));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= ROW_W'(clamp_dim(cfg_data, MAX_HEIGHT));
                end
                REG_MOTION_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[THR_W-1:0];
                end
                default:
                begin
                    // unmapped index, write ignored
                end
            endcase
        end
    end

    // front: counts the raster position, thresholds, drops early flush requests
    tfmm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .cmd        (cmd),
        .prev_pixel (prev_pixel),
        .cur_pixel  (cur_pixel),
        .next_pixel (next_pixel),
        .frame_w    (width_reg),
        .frame_h    (height_reg),
        .threshold  (threshold_reg),
        .queue_full (op_full),
        .op_push    (op_push),
        .op         (op_in)
    );

    // full only reflects the queue, so the front keeps taking requests
    // while results wait at the output, until the request queue fills
    assign full = op_full;

    tfmm_op_queue u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_in),
        .pop   (op_pop),
        .full  (op_full),
        .valid (op_valid),
        .dout  (op_out)
    );

    // back: line buffers, 2x2 erosion, 3x3 dilation; issues only with credit
    // in the result queue
    tfmm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op_out),
        .res_count (res_count),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res       (res_in)
    );

    tfmm_result_fifo u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .pop   (pop),
        .empty (empty),
        .dout  (res_out),
        .count (res_count)
    );

    assign motion_bit = res_out.motion_bit;
    assign frame_last = res_out.frame_last;

    // credit scheme keeps the result queue from overflowing
    `TFMM_ASSERT_IMPLIES(a_res_no_overflow, res_push, res_count < RES_CNT_W'(RES_DEPTH))
    // front never pushes into a full request queue
    `TFMM_ASSERT_IMPLIES(a_opq_push_room, op_push, !op_full)
    // back only pops a request that is there
    `TFMM_ASSERT_IMPLIES(a_opq_pop_valid, op_pop, op_valid)
    // a result pushed is visible on the result side next cycle
    `TFMM_ASSERT_NEXT(a_res_visible, res_push, !empty)

endmodule
